// ----- design/first_fit_segment_allocator_macros.svh -----
// Assertion macros shared by the allocator checker.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FFSA_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("allocator check failed");

// Next-cycle implication, disabled during reset.
`define FFSA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("allocator check failed");

`endif

// ----- design/ffsa_pkg.sv -----
// Types and constants of the first-fit segment allocator.
package ffsa_pkg;

    localparam int MAX_SEGMENTS   = 64;
    localparam int SEG_IDX_W      = $clog2(MAX_SEGMENTS);
    localparam int SEG_CNT_W      = $clog2(MAX_SEGMENTS + 1);
    localparam int MAX_HEAP_PAGES = 4096;
    localparam int PAGE_CNT_W     = 13;
    localparam int PAGE_BYTES     = 4096;
    localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
    localparam int HEADER_BYTES   = 24;
    localparam int ALIGN_BYTES    = 16;
    localparam int ALIGN_SHIFT    = $clog2(ALIGN_BYTES);
    localparam int REQ_W          = 24;
    localparam int SZ_W           = REQ_W + 1;
    localparam int OFF_W          = 24;
    localparam int LINK_W         = SEG_CNT_W;
    localparam int ADDR_W         = 40;
    localparam logic [ADDR_W-1:0] HEAP_BASE = 40'hB000000000;

    // link / tail value meaning "no segment"
    localparam logic [SEG_CNT_W-1:0] SEG_NONE = SEG_CNT_W'(MAX_SEGMENTS);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_NOMEM   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_WR2,
        S_GROW_RD,
        S_GROW_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [OFF_W-1:0]  size;
        logic              is_free;
        logic [LINK_W-1:0] link;
    } seg_t;

endpackage

// ----- design/ffsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/first_fit_segment_allocator.sv -----
// Top level of the first-fit segment allocator.
//
// Input channel (s_valid/s_ready): one word per request. s_operation 0
// allocates s_request_size bytes, 1 frees the block at s_block_address.
// Output channel (m_valid/m_ready): exactly one result word per request,
// with the payload address (zero unless an allocate succeeded), a status
// and the number of heap pages mapped after the request.
// The segment table lives in one 64-entry RAM (offset, size, free, link)
// with a registered read; the walk visits each segment in an address
// state (S_RD) and then a check state (S_CHK), and when the heap grows
// the walk is retried. A split, or a segment appended behind an old
// tail, adds the write state S_WR2. The block works on one request at
// a time.
// Reset (aresetn low, synchronous) empties the heap: no segments, no
// pages, no tail. The RAM is not cleared; only entries below the use
// count are ever read.
// When the receiver stalls, the finished result sits in the output
// register and the next request is still taken; its result waits until
// the output register is free.
module first_fit_segment_allocator
    import ffsa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [REQ_W-1:0]  s_request_size,
    input  logic [ADDR_W-1:0] s_block_address,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ADDR_W-1:0] m_result_address,
    output logic [1:0]        m_status,
    output logic [PAGE_CNT_W-1:0] m_heap_pages_now
);

    state_t state_reg, state_next;

    logic                  op_reg, op_next;
    logic [SZ_W-1:0]       sreq_reg, sreq_next;        // sized request
    logic [ADDR_W-1:0]     want_reg, want_next;
    logic [SEG_CNT_W-1:0]  idx_reg, idx_next;
    logic [SEG_CNT_W-1:0]  steps_reg, steps_next;
    logic                  first_reg, first_next;      // initial one-page map
    logic                  retry_reg, retry_next;
    logic                  search_reg, search_next;    // walk again after WR2
    logic [SEG_CNT_W-1:0]  used_reg, used_next;
    logic [SEG_CNT_W-1:0]  tail_reg, tail_next;
    logic [PAGE_CNT_W-1:0] pages_reg, pages_next;
    status_t               status_reg, status_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [SEG_IDX_W-1:0]  pend_addr_reg, pend_addr_next;
    seg_t                  pend_data_reg, pend_data_next;

    logic                  m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]     m_addr_reg, m_addr_next;
    status_t               m_status_reg, m_status_next;
    logic [PAGE_CNT_W-1:0] m_pages_reg, m_pages_next;

    // RAM port
    logic                 ram_we;
    logic [SEG_IDX_W-1:0] ram_waddr;
    seg_t                 ram_wdata;
    logic [SEG_IDX_W-1:0] ram_raddr;
    seg_t                 ram_rdata;

    ffsa_ram #(
        .WIDTH($bits(seg_t)),
        .DEPTH(MAX_SEGMENTS)
    ) u_seg_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Request sizing: max(size, align) rounded to the next multiple above.
    logic [REQ_W-1:0] size_floor;
    logic [SZ_W-1:0]  size_sized;
    assign size_floor = (s_request_size < REQ_W'(ALIGN_BYTES)) ? REQ_W'(ALIGN_BYTES)
                                                               : s_request_size;
    assign size_sized = {1'b0, size_floor[REQ_W-1:ALIGN_SHIFT], {ALIGN_SHIFT{1'b0}}}
                      + SZ_W'(ALIGN_BYTES);

    logic in_accept, out_free;
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // Walk bookkeeping
    logic walk_end;
    assign walk_end = (steps_reg == SEG_NONE) || (idx_reg >= used_reg);

    // Segment check
    seg_t             cur;
    logic             fit;
    logic [OFF_W-1:0] rest;
    logic             do_split;
    logic [ADDR_W-1:0] cur_addr;
    logic             addr_match;
    assign cur        = ram_rdata;
    assign fit        = cur.is_free && ({1'b0, cur.size} >= sreq_reg);
    assign rest       = cur.size - sreq_reg[OFF_W-1:0];
    assign do_split   = (rest >= OFF_W'(HEADER_BYTES + ALIGN_BYTES)) && (used_reg < SEG_NONE);
    assign cur_addr   = HEAP_BASE + ADDR_W'(cur.offset) + ADDR_W'(HEADER_BYTES);
    assign addr_match = (cur_addr == want_reg);

    // Growth sizing
    logic [SZ_W:0]         need;
    logic [SZ_W:0]         need_rnd;
    logic [PAGE_CNT_W:0]   grow_pages;
    logic [PAGE_CNT_W+1:0] pages_total;
    logic                  grow_limit;
    logic                  tail_ok;
    logic [OFF_W:0]        grow_bytes;
    assign need        = first_reg ? '0 : ({1'b0, sreq_reg} + (SZ_W + 1)'(HEADER_BYTES));
    assign need_rnd    = need + (SZ_W + 1)'(PAGE_BYTES - 1);
    assign grow_pages  = (need_rnd[SZ_W:PAGE_SHIFT] == '0) ? (PAGE_CNT_W + 1)'(1)
                       : (PAGE_CNT_W + 1)'(need_rnd[SZ_W:PAGE_SHIFT]);
    assign pages_total = (PAGE_CNT_W + 2)'(pages_reg) + (PAGE_CNT_W + 2)'(grow_pages);
    assign grow_limit  = pages_total > (PAGE_CNT_W + 2)'(MAX_HEAP_PAGES);
    assign tail_ok     = tail_reg < used_reg;
    assign grow_bytes  = (OFF_W + 1)'(grow_pages) << PAGE_SHIFT;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    if (s_operation == OP_ALLOC && s_request_size == '0) begin
                        state_next = S_DONE;
                    end else if (s_operation == OP_ALLOC && used_reg == '0) begin
                        state_next = S_GROW_RD;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                if (!walk_end) begin
                    state_next = S_CHK;
                end else if (op_reg == OP_ALLOC && !retry_reg) begin
                    state_next = S_GROW_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_CHK: begin
                if (op_reg == OP_ALLOC) begin
                    if (fit) begin
                        state_next = do_split ? S_WR2 : S_DONE;
                    end else begin
                        state_next = S_RD;
                    end
                end else begin
                    state_next = addr_match ? S_DONE : S_RD;
                end
            end
            S_WR2: begin
                state_next = search_reg ? S_RD : S_DONE;
            end
            S_GROW_RD: begin
                state_next = S_GROW_CHK;
            end
            S_GROW_CHK: begin
                if (grow_limit || (!(tail_ok && cur.is_free) && used_reg >= SEG_NONE)) begin
                    state_next = first_reg ? S_RD : S_DONE;
                end else if (tail_ok && !cur.is_free) begin
                    state_next = S_WR2;
                end else begin
                    state_next = S_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and RAM controls
    always_comb begin
        op_next        = op_reg;
        sreq_next      = sreq_reg;
        want_next      = want_reg;
        idx_next       = idx_reg;
        steps_next     = steps_reg;
        first_next     = first_reg;
        retry_next     = retry_reg;
        search_next    = search_reg;
        used_next      = used_reg;
        tail_next      = tail_reg;
        pages_next     = pages_reg;
        status_next    = status_reg;
        addr_next      = addr_reg;
        pend_addr_next = pend_addr_reg;
        pend_data_next = pend_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_addr_next    = m_addr_reg;
        m_status_next  = m_status_reg;
        m_pages_next   = m_pages_reg;
        s_ready        = (state_reg == S_IDLE);
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[SEG_IDX_W-1:0];
        ram_wdata      = cur;
        ram_raddr      = idx_reg[SEG_IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    op_next     = s_operation;
                    sreq_next   = size_sized;
                    want_next   = s_block_address;
                    idx_next    = '0;
                    steps_next  = '0;
                    retry_next  = 1'b0;
                    first_next  = (used_reg == '0);
                    addr_next   = '0;
                    status_next = ST_OK;
                    if (s_operation == OP_ALLOC && s_request_size == '0) begin
                        status_next = ST_ZERO;
                    end
                end
            end
            S_RD: begin
                if (walk_end) begin
                    if (op_reg == OP_ALLOC && !retry_reg) begin
                        retry_next = 1'b1;
                        first_next = 1'b0;
                    end else begin
                        status_next = (op_reg == OP_ALLOC) ? ST_NOMEM : ST_UNKNOWN;
                    end
                end
            end
            S_CHK: begin
                if (op_reg == OP_ALLOC) begin
                    if (fit) begin
                        ram_we           = 1'b1;
                        ram_wdata.is_free = 1'b0;
                        addr_next        = cur_addr;
                        if (do_split) begin
                            ram_wdata.size = sreq_reg[OFF_W-1:0];
                            ram_wdata.link = used_reg;
                            pend_addr_next = used_reg[SEG_IDX_W-1:0];
                            pend_data_next.offset = cur.offset + OFF_W'(HEADER_BYTES)
                                                  + sreq_reg[OFF_W-1:0];
                            pend_data_next.size    = rest - OFF_W'(HEADER_BYTES);
                            pend_data_next.is_free = 1'b1;
                            pend_data_next.link    = cur.link;
                            search_next = 1'b0;
                            used_next   = used_reg + 1'b1;
                            if (cur.link >= used_reg) begin
                                tail_next = used_reg;
                            end
                        end
                    end else begin
                        idx_next   = cur.link;
                        steps_next = steps_reg + 1'b1;
                    end
                end else begin
                    if (addr_match) begin
                        ram_we            = 1'b1;
                        ram_wdata.is_free = 1'b1;
                    end else begin
                        idx_next   = cur.link;
                        steps_next = steps_reg + 1'b1;
                    end
                end
            end
            S_WR2: begin
                ram_we    = 1'b1;
                ram_waddr = pend_addr_reg;
                ram_wdata = pend_data_reg;
            end
            S_GROW_RD: begin
                ram_raddr = tail_reg[SEG_IDX_W-1:0];
            end
            S_GROW_CHK: begin
                idx_next   = '0;
                steps_next = '0;
                ram_waddr  = tail_reg[SEG_IDX_W-1:0];
                if (grow_limit || (!(tail_ok && cur.is_free) && used_reg >= SEG_NONE)) begin
                    if (!first_reg) begin
                        status_next = ST_NOMEM;
                    end
                end else begin
                    pages_next = pages_total[PAGE_CNT_W-1:0];
                    if (tail_ok && cur.is_free) begin
                        // extend the free tail in place
                        ram_we         = 1'b1;
                        ram_wdata.size = cur.size + grow_bytes[OFF_W-1:0];
                    end else begin
                        pend_data_next.offset  = OFF_W'({pages_reg, {PAGE_SHIFT{1'b0}}});
                        pend_data_next.size    = grow_bytes[OFF_W-1:0] - OFF_W'(HEADER_BYTES);
                        pend_data_next.is_free = 1'b1;
                        pend_data_next.link    = SEG_NONE;
                        pend_addr_next         = used_reg[SEG_IDX_W-1:0];
                        used_next              = used_reg + 1'b1;
                        tail_next              = used_reg;
                        search_next            = 1'b1;
                        ram_we                 = 1'b1;
                        if (tail_ok) begin
                            // relink old tail now, new segment in WR2
                            ram_wdata.link = used_reg;
                        end else begin
                            ram_waddr = used_reg[SEG_IDX_W-1:0];
                            ram_wdata.offset  = OFF_W'({pages_reg, {PAGE_SHIFT{1'b0}}});
                            ram_wdata.size    = grow_bytes[OFF_W-1:0] - OFF_W'(HEADER_BYTES);
                            ram_wdata.is_free = 1'b1;
                            ram_wdata.link    = SEG_NONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_addr_next   = (status_reg == ST_OK) ? addr_reg : '0;
                    m_status_next = status_reg;
                    m_pages_next  = pages_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            tail_reg    <= SEG_NONE;
            pages_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            tail_reg    <= tail_next;
            pages_reg   <= pages_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        sreq_reg      <= sreq_next;
        want_reg      <= want_next;
        idx_reg       <= idx_next;
        steps_reg     <= steps_next;
        first_reg     <= first_next;
        retry_reg     <= retry_next;
        search_reg    <= search_next;
        status_reg    <= status_next;
        addr_reg      <= addr_next;
        pend_addr_reg <= pend_addr_next;
        pend_data_reg <= pend_data_next;
        m_addr_reg    <= m_addr_next;
        m_status_reg  <= m_status_next;
        m_pages_reg   <= m_pages_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_result_address = m_addr_reg;
    assign m_status         = m_status_reg;
    assign m_heap_pages_now = m_pages_reg;

endmodule

// ----- design/ffsa_checker.sv -----
// Port-level checks of the allocator, bound to the top level.
`include "first_fit_segment_allocator_macros.svh"

module ffsa_checker
    import ffsa_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [ADDR_W-1:0]     m_result_address,
    input logic [1:0]            m_status,
    input logic [PAGE_CNT_W-1:0] m_heap_pages_now
);

    // one request at a time: input closes right after a word is taken
    `FFSA_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    // stalled result word holds
    `FFSA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result_address) && $stable(m_status))
    // failed requests never carry an address
    `FFSA_ASSERT_IMPLY(a_fail_no_addr, aclk, aresetn, m_valid && m_status != ST_OK, m_result_address == '0)
    // a handed-out address shares the heap base's top four bits, with pages mapped
    `FFSA_ASSERT_IMPLY(a_addr_window, aclk, aresetn, m_valid && m_result_address != '0, m_result_address[ADDR_W-1:ADDR_W-4] == HEAP_BASE[ADDR_W-1:ADDR_W-4] && m_heap_pages_now != '0)
    // page count stays within the heap limit
    `FFSA_ASSERT_IMPLY(a_page_limit, aclk, aresetn, m_valid, m_heap_pages_now <= PAGE_CNT_W'(MAX_HEAP_PAGES))

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_result_address(m_result_address),
    .m_status        (m_status),
    .m_heap_pages_now(m_heap_pages_now)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the first-fit segment allocator.
module testbench;
    import ffsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;
    localparam int RANDOM_WORDS   = 700;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_operation = OP_ALLOC;
    logic [REQ_W-1:0]  s_request_size = '0;
    logic [ADDR_W-1:0] s_block_address = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [ADDR_W-1:0] m_result_address;
    logic [1:0]        m_status;
    logic [PAGE_CNT_W-1:0] m_heap_pages_now;

    first_fit_segment_allocator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_request_size(s_request_size),
        .s_block_address(s_block_address),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_address(m_result_address), .m_status(m_status),
        .m_heap_pages_now(m_heap_pages_now)
    );

    always #4 aclk = ~aclk;

    // One allocator answer: address, status, pages mapped.
    typedef struct {
        logic [ADDR_W-1:0]     addr;
        status_t               status;
        logic [PAGE_CNT_W-1:0] pages;
    } answer_t;

    // Directed row: request plus optional typed-in answer.
    typedef struct {
        logic              op;
        logic [REQ_W-1:0]  size;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        answer_t           ans;
    } row_t;

    answer_t pending_answers[$];
    logic [ADDR_W-1:0] live_blocks[$];  // addresses handed out so far
    int  errors = 0;
    int  idle_cycles = 0;

    // Shadow heap state.
    longint unsigned seg_off[MAX_SEGMENTS];
    longint unsigned seg_len[MAX_SEGMENTS];
    bit              seg_free[MAX_SEGMENTS];
    int              seg_next[MAX_SEGMENTS];
    int              seg_count = 0;
    int              heap_tail = MAX_SEGMENTS;  // no segment yet
    longint unsigned heap_pages = 0;

    function automatic int add_segment(longint unsigned off, longint unsigned len);
        int k;
        k = seg_count;
        seg_off[k] = off;
        seg_len[k] = len;
        seg_free[k] = 1'b1;
        seg_next[k] = MAX_SEGMENTS;
        seg_count = k + 1;
        return k;
    endfunction

    function automatic bit map_pages(longint unsigned need);
        longint unsigned pages;
        int k;
        pages = (need + PAGE_BYTES - 1) / PAGE_BYTES;
        if (pages == 0) pages = 1;
        if (heap_pages > MAX_HEAP_PAGES || pages > MAX_HEAP_PAGES - heap_pages)
            return 1'b0;
        if (heap_tail < seg_count && seg_free[heap_tail]) begin
            seg_len[heap_tail] += pages * PAGE_BYTES;
        end else begin
            if (seg_count >= MAX_SEGMENTS) return 1'b0;
            k = add_segment(heap_pages * PAGE_BYTES, pages * PAGE_BYTES - HEADER_BYTES);
            if (heap_tail < seg_count) seg_next[heap_tail] = k;
            heap_tail = k;
        end
        heap_pages += pages;
        return 1'b1;
    endfunction

    // First-fit walk; splits when the surplus holds a header plus one grain.
    function automatic int first_fit(longint unsigned want);
        int idx;
        int k;
        longint unsigned rest;
        idx = 0;
        for (int steps = 0; steps < MAX_SEGMENTS && idx < seg_count; steps++) begin
            if (seg_free[idx] && seg_len[idx] >= want) begin
                rest = seg_len[idx] - want;
                if (rest >= HEADER_BYTES + ALIGN_BYTES && seg_count < MAX_SEGMENTS) begin
                    k = add_segment(seg_off[idx] + HEADER_BYTES + want, rest - HEADER_BYTES);
                    seg_next[k] = seg_next[idx];
                    if (seg_next[idx] >= seg_count - 1) heap_tail = k;
                    seg_next[idx] = k;
                    seg_len[idx] = want;
                end
                seg_free[idx] = 1'b0;
                return idx;
            end
            idx = seg_next[idx];
        end
        return MAX_SEGMENTS;
    endfunction

    function automatic answer_t allocator_answer(logic op, logic [REQ_W-1:0] size,
                                                 logic [ADDR_W-1:0] addr);
        answer_t a;
        longint unsigned s;
        int idx;
        logic [ADDR_W-1:0] payload;
        a.addr = '0;
        a.status = ST_OK;
        if (op == OP_ALLOC) begin
            s = size;
            if (s == 0) begin
                a.status = ST_ZERO;
            end else begin
                if (s < ALIGN_BYTES) s = ALIGN_BYTES;
                s = s + (ALIGN_BYTES - (s % ALIGN_BYTES));
                if (seg_count == 0) void'(map_pages(0));
                idx = first_fit(s);
                if (idx == MAX_SEGMENTS && map_pages(s + HEADER_BYTES)) idx = first_fit(s);
                if (idx == MAX_SEGMENTS) begin
                    a.status = ST_NOMEM;
                end else begin
                    a.addr = ADDR_W'(HEAP_BASE + seg_off[idx] + HEADER_BYTES);
                    live_blocks.push_back(a.addr);
                end
            end
        end else begin
            a.status = ST_UNKNOWN;
            idx = 0;
            for (int steps = 0; steps < MAX_SEGMENTS && idx < seg_count; steps++) begin
                payload = ADDR_W'(HEAP_BASE + seg_off[idx] + HEADER_BYTES);
                if (payload == addr) begin
                    seg_free[idx] = 1'b1;
                    a.status = ST_OK;
                    break;
                end
                idx = seg_next[idx];
            end
        end
        a.pages = heap_pages[PAGE_CNT_W-1:0];
        return a;
    endfunction

    // Drive one word and wait for acceptance; idle before it sometimes.
    task automatic send_word(logic op, logic [REQ_W-1:0] size, logic [ADDR_W-1:0] addr,
                             int gap);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_request_size <= size;
        s_block_address <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Compute expectation at acceptance so the predictor order matches the block.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            pending_answers.push_back(allocator_answer(s_operation, s_request_size,
                                                       s_block_address));
    end

    // Result checker.
    always @(posedge aclk) begin
        answer_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = pending_answers.pop_front();
                if (m_result_address !== e.addr) begin
                    $error("result_address expected %h actual %h", e.addr, m_result_address);
                    errors++;
                end
                if (m_status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, m_status);
                    errors++;
                end
                if (m_heap_pages_now !== e.pages) begin
                    $error("heap_pages_now expected %0d actual %0d", e.pages,
                           m_heap_pages_now);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls: alternates stall-heavy and free-flowing stretches.
    always @(negedge aclk) begin
        int phase;
        phase = int'(($time / 8000) % 4);
        if (phase == 0) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0) || phase == 2 ? ($urandom_range(0, 1) == 1)
                                                                  : 1'b0;
    end

    // Watchdog on cycles with no accepted word.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (aresetn && idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Random request mix: allocations, frees of live blocks, frees just past a live block, and random frees.
    task automatic random_word(int gap);
        int pick;
        logic [REQ_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(0, 99);
        addr = ADDR_W'({$urandom, $urandom});
        if (pick < 45) begin
            case ($urandom_range(0, 5))
                0: size = REQ_W'($urandom_range(1, 16));
                1: size = REQ_W'($urandom_range(17, 256));
                2: size = REQ_W'($urandom_range(257, 4096));
                3: size = REQ_W'($urandom_range(4097, 40000));
                4: size = REQ_W'($urandom);
                default: size = '0;
            endcase
            send_word(OP_ALLOC, size, addr, gap);
        end else if (pick < 85 && live_blocks.size() != 0) begin
            addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            send_word(OP_FREE, REQ_W'($urandom), addr, gap);
        end else if (pick < 92 && live_blocks.size() != 0) begin
            addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)] + 16;
            send_word(OP_FREE, REQ_W'($urandom), addr, gap);
        end else begin
            send_word(OP_FREE, REQ_W'($urandom), addr, gap);
        end
    endtask

    row_t directed_rows[$];

    function automatic row_t make_row(logic op, logic [REQ_W-1:0] size,
                                      logic [ADDR_W-1:0] addr, bit typed,
                                      logic [ADDR_W-1:0] e_addr, status_t e_st,
                                      logic [PAGE_CNT_W-1:0] e_pages);
        row_t r;
        r.op = op; r.size = size; r.addr = addr; r.typed = typed;
        r.ans.addr = e_addr; r.ans.status = e_st; r.ans.pages = e_pages;
        return r;
    endfunction

    initial begin
        answer_t got;
        int burst;
        // Free before the heap exists, zero size, first allocation, extremes.
        directed_rows.push_back(make_row(OP_FREE, 0, HEAP_BASE + 24, 1, 0, ST_UNKNOWN, 0));
        directed_rows.push_back(make_row(OP_FREE, '1, '1, 1, 0, ST_UNKNOWN, 0));
        directed_rows.push_back(make_row(OP_ALLOC, 0, '1, 1, 0, ST_ZERO, 0));
        directed_rows.push_back(make_row(OP_ALLOC, 1, 0, 1, HEAP_BASE + 24, ST_OK, 1));
        directed_rows.push_back(make_row(OP_ALLOC, 16, 0, 1, HEAP_BASE + 80, ST_OK, 1));
        directed_rows.push_back(make_row(OP_ALLOC, 17, 0, 0, 0, ST_OK, 0));
        directed_rows.push_back(make_row(OP_ALLOC, 32, 0, 0, 0, ST_OK, 0));
        directed_rows.push_back(make_row(OP_FREE, 0, HEAP_BASE + 24, 1, 0, ST_OK, 1));
        directed_rows.push_back(make_row(OP_FREE, 0, HEAP_BASE + 24, 1, 0, ST_OK, 1));
        directed_rows.push_back(make_row(OP_FREE, 0, HEAP_BASE + 25, 1, 0, ST_UNKNOWN, 1));
        directed_rows.push_back(make_row(OP_ALLOC, 20, 0, 0, 0, ST_OK, 0));
        directed_rows.push_back(make_row(OP_ALLOC, 4000, 0, 0, 0, ST_OK, 0));
        directed_rows.push_back(make_row(OP_ALLOC, 4096, 0, 0, 0, ST_OK, 0));
        // largest request needs more than the whole heap; four pages mapped so far
        directed_rows.push_back(make_row(OP_ALLOC, '1, 0, 1, 0, ST_NOMEM, 4));
        directed_rows.push_back(make_row(OP_ALLOC, 24'h800000, 0, 0, 0, ST_OK, 0));
        directed_rows.push_back(make_row(OP_ALLOC, 24'h7FFFFF, 0, 0, 0, ST_OK, 0));
        directed_rows.push_back(make_row(OP_ALLOC, 24'hFFFF00, 0, 0, 0, ST_OK, 0));

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // Every row goes through the predictor; typed rows also pin the
        // predictor's answer to the hand-computed one.
        for (int i = 0; i < directed_rows.size(); i++) begin
            send_word(directed_rows[i].op, directed_rows[i].size, directed_rows[i].addr,
                      $urandom_range(0, 2));
            if (directed_rows[i].typed) begin
                got = pending_answers[$];
                if (got.addr !== directed_rows[i].ans.addr) begin
                    $error("row %0d: result_address expected %h actual %h", i,
                           directed_rows[i].ans.addr, got.addr);
                    errors++;
                end
                if (got.status !== directed_rows[i].ans.status) begin
                    $error("row %0d: status expected %0d actual %0d", i,
                           directed_rows[i].ans.status, got.status);
                    errors++;
                end
                if (got.pages !== directed_rows[i].ans.pages) begin
                    $error("row %0d: heap_pages_now expected %0d actual %0d", i,
                           directed_rows[i].ans.pages, got.pages);
                    errors++;
                end
            end
        end

        // Random part in bursts, with one drain pause in the middle.
        burst = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2) begin
                s_valid <= 1'b0;
                while (pending_answers.size() != 0) @(negedge aclk);
            end
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                random_word($urandom_range(1, 30));
            end else begin
                random_word(0);
            end
            burst--;
        end
        s_valid <= 1'b0;

        while (pending_answers.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+design
design/ffsa_pkg.sv
design/ffsa_ram.sv
design/first_fit_segment_allocator.sv
design/ffsa_checker.sv
tb/testbench.sv
